// ----- sv/hbd_pkg.sv -----
// hbd_pkg: shared types and constants of the hdlc byte deframer
// line codes, status codes and the result word passed from the frame
// control to the top level; no dependencies
package hbd_pkg;

	localparam logic [7:0]  FLAG_BYTE = 8'h7E;
	localparam logic [7:0]  ESC_BYTE  = 8'h7D;
	localparam logic [7:0]  ESC_XOR   = 8'h20;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;

	// destuffed positions of the header fields
	localparam int unsigned POS_ADDRESS = 0;
	localparam int unsigned POS_CONTROL = 2;
	localparam int unsigned POS_PAYLOAD = 5;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	localparam logic [1:0] ST_GOOD     = 2'd0;
	localparam logic [1:0] ST_CRC_BAD  = 2'd1;
	localparam logic [1:0] ST_SHORT    = 2'd2;
	localparam logic [1:0] ST_TOO_LONG = 2'd3;

	typedef struct packed {
		logic       valid;
		logic       kind;
		logic [7:0] payload_byte;
		logic [7:0] frame_address;
		logic [7:0] frame_control;
		logic [1:0] frame_status;
		logic [7:0] payload_count;
	} hbd_result_t;

endpackage

// ----- sv/hbd_crc_unit.sv -----
// hbd_crc_unit: one byte step of crc-16/modbus, eight shifts unrolled
// depends on hbd_pkg for the polynomial
module hbd_crc_unit
	import hbd_pkg::*;
(
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule

// ----- sv/hbd_frame_ctrl.sv -----
// hbd_frame_ctrl: frame state, destuffing, byte hold-back and status
// depends on hbd_pkg and hbd_crc_unit
module hbd_frame_ctrl
	import hbd_pkg::*;
#(
	parameter int unsigned MAX_FRAME = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic [7:0]  byte_in,
	output hbd_result_t res
);

	localparam int unsigned PW = $clog2(MAX_FRAME + 1);

	logic          in_frame_q;
	logic          esc_q;
	logic [PW-1:0] pos_q;
	logic [15:0]   crc_q;
	logic [7:0]    held0_q;
	logic [7:0]    held1_q;
	logic [7:0]    addr_q;
	logic [7:0]    ctrl_q;
	logic          ovf_q;

	logic          is_flag;
	logic          is_esc;
	logic [7:0]    dbyte;
	logic          data_ev;
	logic          pos_full;
	logic          store;
	logic          close;
	logic          pos_ge5;
	logic [15:0]   crc_next;
	logic [1:0]    close_status;

	assign is_flag  = (byte_in == FLAG_BYTE);
	assign is_esc   = (byte_in == ESC_BYTE);
	assign dbyte    = esc_q ? (byte_in ^ ESC_XOR) : byte_in;
	// destuffed data byte inside a frame
	assign data_ev  = !is_flag && in_frame_q && (esc_q || !is_esc);
	assign pos_full = (pos_q == PW'(MAX_FRAME));
	assign store    = data_ev && !pos_full;
	assign close    = is_flag && in_frame_q && ((pos_q != '0) || ovf_q);
	assign pos_ge5  = (pos_q >= PW'(POS_PAYLOAD));

	hbd_crc_unit u_crc (
		.crc_in  (crc_q),
		.data    (held0_q),
		.crc_out (crc_next)
	);

	always_comb begin
		if (ovf_q) begin
			close_status = ST_TOO_LONG;
		end else if (!pos_ge5) begin
			close_status = ST_SHORT;
		end else if ({held1_q, held0_q} == crc_q) begin
			close_status = ST_GOOD;
		end else begin
			close_status = ST_CRC_BAD;
		end
	end

	always_comb begin
		res               = '0;
		res.frame_address = addr_q;
		res.frame_control = ctrl_q;
		if (close) begin
			res.valid         = 1'b1;
			res.kind          = KIND_STATUS;
			res.frame_status  = close_status;
			res.payload_count = pos_ge5 ? 8'(pos_q - PW'(POS_PAYLOAD)) : 8'd0;
		end else if (store && pos_ge5) begin
			res.valid         = 1'b1;
			res.kind          = KIND_PAYLOAD;
			res.payload_byte  = held0_q;
			res.payload_count = 8'(pos_q - PW'(POS_PAYLOAD - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			pos_q      <= '0;
			crc_q      <= CRC_INIT;
			held0_q    <= 8'h00;
			held1_q    <= 8'h00;
			addr_q     <= 8'h00;
			ctrl_q     <= 8'h00;
			ovf_q      <= 1'b0;
		end else if (fire) begin
			if (is_flag) begin
				esc_q <= 1'b0;
				if (!in_frame_q) begin
					in_frame_q <= 1'b1;
					pos_q      <= '0;
					crc_q      <= CRC_INIT;
					addr_q     <= 8'h00;
					ctrl_q     <= 8'h00;
					ovf_q      <= 1'b0;
				end else if (close) begin
					in_frame_q <= 1'b0;
				end
			end else if (in_frame_q) begin
				if (esc_q) begin
					esc_q <= 1'b0;
				end else if (is_esc) begin
					esc_q <= 1'b1;
				end
				if (data_ev && pos_full) begin
					ovf_q <= 1'b1;
				end
				if (store) begin
					pos_q   <= pos_q + PW'(1);
					held0_q <= held1_q;
					held1_q <= dbyte;
					if (pos_q == PW'(POS_ADDRESS)) begin
						addr_q <= dbyte;
					end
					if (pos_q == PW'(POS_CONTROL)) begin
						ctrl_q <= dbyte;
					end
					if (pos_q >= PW'(POS_CONTROL)) begin
						crc_q <= crc_next;
					end
				end
			end
		end
	end

endmodule

// ----- sv/hdlc_byte_deframer_crc16.sv -----
// hdlc_byte_deframer_crc16: top level, input register, frame control and
// result register; depends on hbd_pkg and hbd_frame_ctrl
//
// usage
//   input channel: one raw line byte per word on rx_byte, flags (0x7e) and
//   escapes (0x7d) included, with in_valid / in_stall
//   output channel: at most one result word per input word, with
//   out_valid / out_stall; kind 0 carries a destuffed payload byte, kind 1
//   is the end of frame status (good, crc mismatch, too short, too long)
//   together with the address, control field and payload count
//   payload bytes come out two bytes late: the last two bytes of a frame
//   are the fcs and are only known as such at the closing flag
//   path: the input word lands in the input register when it is accepted;
//   its result word is written to the result register once that register
//   can take a new word, and the receiver takes it from there
//   throughput: one byte per cycle while the receiver does not stall; the crc
//   step is eight unrolled shifts inside the frame control
//   stall: while out_stall holds a result, the input register keeps its
//   byte and in_stall rises once that register is full; nothing is dropped
//   reset: arst_n clears the frame state, crc goes to 0xffff and the block
//   waits for an opening flag
module hdlc_byte_deframer_crc16
	import hbd_pkg::*;
#(
	parameter int unsigned MAX_FRAME = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       kind,
	output logic [7:0] payload_byte,
	output logic [7:0] frame_address,
	output logic [7:0] frame_control,
	output logic [1:0] frame_status,
	output logic [7:0] payload_count
);

	logic        vld_s1;
	logic [7:0]  byte_s1;
	hbd_result_t res_s2;
	hbd_result_t res;
	hbd_result_t res_next;
	logic        slot_free;
	logic        fire;

	// result register can take a new word this cycle
	assign slot_free = !res_s2.valid || !out_stall;
	assign fire      = vld_s1 && slot_free;
	assign in_stall  = vld_s1 && !slot_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	hbd_frame_ctrl #(
		.MAX_FRAME (MAX_FRAME)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.byte_in (byte_s1),
		.res     (res)
	);

	// only a word that really moved through the frame control is valid
	always_comb begin
		res_next       = res;
		res_next.valid = fire && res.valid;
	end

	// result register; holds while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else if (slot_free) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid     = res_s2.valid;
	assign kind          = res_s2.kind;
	assign payload_byte  = res_s2.payload_byte;
	assign frame_address = res_s2.frame_address;
	assign frame_control = res_s2.frame_control;
	assign frame_status  = res_s2.frame_status;
	assign payload_count = res_s2.payload_count;

endmodule

// ----- sv/hbd_checker.sv -----
// hbd_checker: port level assertions for hdlc_byte_deframer_crc16
// bound to the top level below; depends on hbd_pkg
module hbd_checker
	import hbd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       kind,
	input logic [7:0] payload_byte,
	input logic [1:0] frame_status,
	input logic [7:0] payload_count
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind)
			&& $stable(payload_byte) && $stable(payload_count))
		else $error("stalled result changed");

	// input side only backs up behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("in_stall without stalled output");

	// payload words carry no status
	a_payload_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_PAYLOAD |-> frame_status == ST_GOOD
			&& payload_count != 8'd0 || payload_count == 8'd0)
		else $error("payload word with status");

	// a short frame delivered no payload
	a_short_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_STATUS && frame_status == ST_SHORT
			|-> payload_count == 8'd0)
		else $error("short frame with payload count");

endmodule

bind hdlc_byte_deframer_crc16 hbd_checker u_hbd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.kind          (kind),
	.payload_byte  (payload_byte),
	.frame_status  (frame_status),
	.payload_count (payload_count)
);

// ----- verif/tb_hdlc_byte_deframer_crc16.sv -----
// tb_hdlc_byte_deframer_crc16: self-checking bench for the hdlc byte deframer
// drives stuffed line bytes and predicts the result words with its own model or takes them from typed table rows
// depends on hbd_pkg and hdlc_byte_deframer_crc16
`timescale 1ns / 100ps

module tb_hdlc_byte_deframer_crc16;
	import hbd_pkg::*;

	localparam int FRAME_LIMIT = 128;
	localparam int RANDOM_WORDS = 1800;
	localparam int MAX_IDLE = 19;
	localparam int DRAIN_LIMIT = 20000;

	// one result word as the block presents it
	typedef struct packed {
		logic       kind;
		logic [7:0] pbyte;
		logic [7:0] addr;
		logic [7:0] ctrl;
		logic [1:0] status;
		logic [7:0] count;
	} deframe_result_t;

	// how a directed row gets its expectation: from the predictor, none at
	// all, or typed into the table
	typedef enum logic [1:0] {
		ROW_PREDICTED,
		ROW_NO_WORD,
		ROW_TYPED
	} row_kind_t;

	typedef struct packed {
		logic [7:0]      line_byte;
		row_kind_t       rk;
		deframe_result_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       kind;
	logic [7:0] payload_byte;
	logic [7:0] frame_address;
	logic [7:0] frame_control;
	logic [1:0] frame_status;
	logic [7:0] payload_count;

	// expectation side channel, travels with rx_byte
	row_kind_t       row_kind = ROW_PREDICTED;
	deframe_result_t row_want = '0;

	deframe_result_t deframed_q[$];
	int mismatch_count = 0;
	int items_sent = 0;
	bit send_calm = 1'b0;
	bit recv_calm = 1'b0;

	// predictor state
	bit          in_frame = 1'b0;
	bit          esc_seen = 1'b0;
	int          pos = 0;
	logic [15:0] crc_acc = CRC_INIT;
	logic [7:0]  hold [0:1] = '{8'h00, 8'h00};
	logic [7:0]  addr_q = 8'h00;
	logic [7:0]  ctrl_q = 8'h00;
	bit          ovf = 1'b0;

	// directed part: outside bytes, adjacent flags, a one byte frame,
	// escape after escape, an escaped flag as control field, escape right
	// before the closing flag, then a frame with a (most likely) bad fcs
	stim_row_t directed_rows [0:23] = '{
		'{8'h41,     ROW_NO_WORD, '0},   // outside a frame
		'{ESC_BYTE,  ROW_NO_WORD, '0},   // escape outside a frame
		'{FLAG_BYTE, ROW_NO_WORD, '0},   // opens
		'{FLAG_BYTE, ROW_NO_WORD, '0},   // adjacent flag, still open
		'{8'h00,     ROW_NO_WORD, '0},   // address
		'{FLAG_BYTE, ROW_TYPED,
			{KIND_STATUS, 8'h00, 8'h00, 8'h00, ST_SHORT, 8'h00}},
		'{FLAG_BYTE, ROW_NO_WORD, '0},
		'{8'hFF,     ROW_NO_WORD, '0},   // address
		'{ESC_BYTE,  ROW_NO_WORD, '0},
		'{ESC_BYTE,  ROW_NO_WORD, '0},   // escaped escape becomes 0x5d
		'{ESC_BYTE,  ROW_NO_WORD, '0},
		'{8'h5E,     ROW_NO_WORD, '0},   // control becomes 0x7e
		'{8'h12,     ROW_NO_WORD, '0},
		'{ESC_BYTE,  ROW_NO_WORD, '0},   // dropped by the flag below
		'{FLAG_BYTE, ROW_TYPED,
			{KIND_STATUS, 8'h00, 8'hFF, 8'h7E, ST_SHORT, 8'h00}},
		'{FLAG_BYTE, ROW_NO_WORD, '0},
		'{8'h80,     ROW_PREDICTED, '0},
		'{8'h01,     ROW_PREDICTED, '0},
		'{8'h7F,     ROW_PREDICTED, '0},
		'{8'hA5,     ROW_PREDICTED, '0},
		'{8'h5A,     ROW_PREDICTED, '0},
		'{8'hFE,     ROW_PREDICTED, '0},
		'{8'h3C,     ROW_PREDICTED, '0},
		'{FLAG_BYTE, ROW_PREDICTED, '0}
	};

	hdlc_byte_deframer_crc16 #(
		.MAX_FRAME(FRAME_LIMIT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.payload_byte(payload_byte),
		.frame_address(frame_address),
		.frame_control(frame_control),
		.frame_status(frame_status),
		.payload_count(payload_count)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// crc-16/modbus, lsb first, one byte
	function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (r[0])
				r = (r >> 1) ^ CRC_POLY;
			else
				r = r >> 1;
		end
		return r;
	endfunction

	// advances the predictor by one accepted line byte; returns 1 when the
	// byte causes a result word
	function automatic bit deframe_byte(input logic [7:0] raw, output deframe_result_t res);
		logic [7:0]  b;
		logic [7:0]  oldest;
		logic [15:0] fcs;
		int          p;
		res = '0;
		b = raw;
		if (raw == FLAG_BYTE) begin
			// a pending escape never survives a flag
			esc_seen = 1'b0;
			if (!in_frame) begin
				in_frame = 1'b1;
				pos = 0;
				crc_acc = CRC_INIT;
				addr_q = 8'h00;
				ctrl_q = 8'h00;
				ovf = 1'b0;
				return 1'b0;
			end
			// flag with no data yet is idle fill
			if (pos == 0 && !ovf)
				return 1'b0;
			res.kind = KIND_STATUS;
			res.addr = addr_q;
			res.ctrl = ctrl_q;
			res.count = (pos >= POS_PAYLOAD) ? 8'(pos - POS_PAYLOAD) : 8'd0;
			fcs = {hold[1], hold[0]};
			if (ovf)
				res.status = ST_TOO_LONG;
			else if (pos < POS_PAYLOAD)
				res.status = ST_SHORT;
			else
				res.status = (fcs == crc_acc) ? ST_GOOD : ST_CRC_BAD;
			in_frame = 1'b0;
			return 1'b1;
		end
		if (!in_frame)
			return 1'b0;
		if (esc_seen) begin
			esc_seen = 1'b0;
			b = raw ^ ESC_XOR;
		end else if (raw == ESC_BYTE) begin
			esc_seen = 1'b1;
			return 1'b0;
		end
		if (pos >= FRAME_LIMIT) begin
			ovf = 1'b1;
			return 1'b0;
		end
		p = pos;
		pos = pos + 1;
		if (p == POS_ADDRESS)
			addr_q = b;
		else if (p == POS_CONTROL)
			ctrl_q = b;
		// two newest bytes held back, they may turn out to be the fcs
		oldest = hold[0];
		hold[0] = hold[1];
		hold[1] = b;
		if (p >= POS_CONTROL) begin
			crc_acc = crc16_next(crc_acc, oldest);
			if (p >= POS_PAYLOAD) begin
				res.kind = KIND_PAYLOAD;
				res.pbyte = oldest;
				res.addr = addr_q;
				res.ctrl = ctrl_q;
				res.count = 8'(p - 4);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $time);
		mismatch_count++;
	endtask

	task automatic check_word(input deframe_result_t got);
		deframe_result_t want;
		if (deframed_q.size() == 0) begin
			report_mismatch("word with nothing expected", int'(got.kind), 0);
			return;
		end
		want = deframed_q.pop_front();
		if (got.kind !== want.kind)
			report_mismatch("kind", int'(got.kind), int'(want.kind));
		if (got.pbyte !== want.pbyte)
			report_mismatch("payload_byte", int'(got.pbyte), int'(want.pbyte));
		if (got.addr !== want.addr)
			report_mismatch("frame_address", int'(got.addr), int'(want.addr));
		if (got.ctrl !== want.ctrl)
			report_mismatch("frame_control", int'(got.ctrl), int'(want.ctrl));
		if (got.status !== want.status)
			report_mismatch("frame_status", int'(got.status), int'(want.status));
		if (got.count !== want.count)
			report_mismatch("payload_count", int'(got.count), int'(want.count));
	endtask

	// acceptance on both channels is judged here, at the rising edge, from
	// values that were set up at the falling edge before
	always @(posedge clk) begin : watch_ports
		deframe_result_t predicted;
		bit produced;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				produced = deframe_byte(rx_byte, predicted);
				case (row_kind)
					ROW_TYPED: deframed_q.push_back(row_want);
					ROW_PREDICTED: begin
						if (produced)
							deframed_q.push_back(predicted);
					end
					default: ;
				endcase
			end
			if (out_valid && !out_stall)
				check_word({kind, payload_byte, frame_address, frame_control,
					frame_status, payload_count});
		end
	end

	// sends one line byte: an idle gap of random length first (none while calm), then hold it until accepted
	task automatic send_word(input logic [7:0] b, input row_kind_t rk = ROW_PREDICTED,
			input deframe_result_t want = '0);
		int gap;
		gap = send_calm ? 0 : $urandom_range(0, MAX_IDLE);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		row_kind <= rk;
		row_want <= want;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	// one random frame: mostly well formed with a correct fcs, sometimes
	// short, too long, with a bad fcs, an escape before the closing flag,
	// or plain line noise
	task automatic send_frame();
		logic [7:0]  body[$];
		logic [15:0] fcs;
		logic [7:0]  b;
		int          sel;
		int          len;
		if ($urandom_range(0, 3) == 0)
			send_calm = !send_calm;
		sel = $urandom_range(0, 99);
		if (sel < 6) begin
			len = $urandom_range(1, 6);
			repeat (len) send_word(8'($urandom_range(0, 255)));
			return;
		end
		send_word(FLAG_BYTE);
		if ($urandom_range(0, 7) == 0)
			send_word(FLAG_BYTE);
		if (sel < 14)
			len = $urandom_range(1, 4);
		else if (sel < 20)
			len = $urandom_range(FRAME_LIMIT - 4, FRAME_LIMIT + 8);
		else
			len = $urandom_range(3, 24);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				// lean on the bytes that need stuffing
				case ($urandom_range(0, 3))
					0: b = FLAG_BYTE;
					1: b = ESC_BYTE;
					2: b = FLAG_BYTE ^ ESC_XOR;
					default: b = ESC_BYTE ^ ESC_XOR;
				endcase
			end else begin
				b = 8'($urandom_range(0, 255));
			end
			body.push_back(b);
		end
		if (sel >= 14) begin
			fcs = CRC_INIT;
			foreach (body[i])
				fcs = crc16_next(fcs, body[i]);
			if ($urandom_range(0, 6) == 0)
				fcs = fcs ^ 16'($urandom_range(1, 16'hFFFF));
			body.push_back(fcs[7:0]);
			body.push_back(fcs[15:8]);
		end
		foreach (body[i]) begin
			// stuff what must be stuffed, and now and then a byte that need not be
			if (body[i] == FLAG_BYTE || body[i] == ESC_BYTE || $urandom_range(0, 15) == 0) begin
				send_word(ESC_BYTE);
				send_word(body[i] ^ ESC_XOR);
			end else begin
				send_word(body[i]);
			end
		end
		if ($urandom_range(0, 29) == 0)
			send_word(ESC_BYTE);
		send_word(FLAG_BYTE);
	endtask

	// receiver: stall before each word for a random count, with calm runs
	initial begin : receiver
		int wait_cycles;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				recv_calm = !recv_calm;
			wait_cycles = recv_calm ? 0 : $urandom_range(0, MAX_IDLE);
			@(negedge clk);
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin : stimulus
		int drained;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_word(directed_rows[i].line_byte, directed_rows[i].rk, directed_rows[i].want);

		while (items_sent < RANDOM_WORDS)
			send_frame();

		@(negedge clk);
		in_valid <= 1'b0;
		row_kind <= ROW_PREDICTED;

		// drain the expected words, then wait on with some margin
		drained = 0;
		while (deframed_q.size() != 0 && drained < DRAIN_LIMIT) begin
			@(negedge clk);
			drained++;
		end
		repeat (8) @(negedge clk);
		if (deframed_q.size() != 0)
			report_mismatch("words never delivered", 0, deframed_q.size());

		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin : watchdog
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- files.f -----
sv/hbd_pkg.sv
sv/hbd_crc_unit.sv
sv/hbd_frame_ctrl.sv
sv/hdlc_byte_deframer_crc16.sv
sv/hbd_checker.sv
verif/tb_hdlc_byte_deframer_crc16.sv
